// ----- src/efp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal package
// Shared types, widths, register indexes and a helper function for the
// escape-time fractal pixel unit.
// ----------------------------------------------------------------------------
package efp_pkg;

    // Image and pixel index widths.
    localparam int IMAGE_SIZE = 1024;
    localparam int COORD_W    = $clog2(IMAGE_SIZE);

    // Fixed-point and arithmetic widths.
    localparam int VAL_W      = 32;             // complex component width
    localparam int PROD_W     = 2 * VAL_W;      // full product width
    localparam int SUM_W      = PROD_W + 2;     // room for a three-term sum
    localparam int MOD_W      = PROD_W + 1;     // sum of two squares, unsigned
    localparam int STEP_W     = 31;
    localparam int LIMIT_SQ_W = 31;

    // Iteration count and colour ramp.
    localparam int COUNT_W    = 16;
    localparam int COLOUR_W   = 8;
    localparam int DIV_Q_W    = 9;              // ramp index stays below 510
    localparam int DIVIDEND_W = COUNT_W + DIV_Q_W;
    localparam logic [DIV_Q_W-1:0] COLOUR_MAX  = 9'd255;
    localparam logic [DIV_Q_W-1:0] COLOUR_SPAN = 9'd510;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIMIT  = 3'd7;

    // Saturation bounds of a 32-bit signed value, at sum width.
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    // One pixel request.
    typedef struct packed {
        logic [COORD_W-1:0] pix_col;
        logic [COORD_W-1:0] pix_row;
    } efp_in_t;

    // One pixel result.
    typedef struct packed {
        logic [COORD_W-1:0]  out_col;
        logic [COORD_W-1:0]  out_row;
        logic                draw;
        logic [COUNT_W-1:0]  escape_count;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } efp_out_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_PIM,
        ST_ZRR,
        ST_ZII,
        ST_RI,
        ST_NEW,
        ST_SQR,
        ST_SQI,
        ST_CMP,
        ST_DIV
    } efp_state_t;

    // Clamp a wide signed sum to the 32-bit signed range.
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[VAL_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[VAL_W-1:0];
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/efp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 by 32 multiplier with a registered 64-bit product. All point
// mapping and complex squaring work of the pixel unit goes through it.
// ----------------------------------------------------------------------------
module efp_mul
    import efp_pkg::*;
(
    input  logic                     clk,
    input  logic signed [VAL_W-1:0]  op_a,
    input  logic signed [VAL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] product_reg;

    // The product of two 32-bit signed values always fits in 64 bits.
    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = product_reg;

endmodule

// ----- src/efp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour ramp divider
// Restoring divider, one quotient bit per cycle, for a quotient known to be
// below 512. It produces the ramp index count*510/limit.
// ----------------------------------------------------------------------------
module efp_div
    import efp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [COUNT_W-1:0]    divisor,
    output logic                  done,
    output logic [DIV_Q_W-1:0]    quotient
);

    localparam int STEP_CNT_W = $clog2(DIV_Q_W);
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_Q_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [DIV_Q_W-1:0]    work_reg;
    logic [COUNT_W:0]      trial;
    logic                  fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_reg, work_reg[DIV_Q_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    // Control: counts the quotient bits and flags the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Datapath: the upper dividend bits start below the divisor, since the
    // quotient is known to fit in nine bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend[DIVIDEND_W-1:DIV_Q_W];
            work_reg <= dividend[DIV_Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
            work_reg <= {work_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

// ----- src/escape_time_fractal_pixel_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel unit
// Maps one pixel to a complex point and runs the Mandelbrot or Julia
// iteration in Q8.24 fixed point, then colours escaped pixels.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the result appears. One multiplier serves the whole pixel, and
// each iteration costs it three products; a point that escapes also goes
// through a bit-serial division for the colour ramp. With an iteration limit
// of zero the result follows without any iteration. The default limit is
// 256. The result is shown for a single cycle, marked by done, and stays on
// result until the next result replaces it. Configuration writes must only
// be made while busy is low; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit
    import efp_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  efp_in_t               pixel,
    output logic                  done,
    output efp_out_t              result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    // Configuration registers.
    logic signed [VAL_W-1:0]   origin_re_reg;
    logic signed [VAL_W-1:0]   origin_im_reg;
    logic [STEP_W-1:0]         pixel_step_reg;
    logic signed [VAL_W-1:0]   julia_re_reg;
    logic signed [VAL_W-1:0]   julia_im_reg;
    logic                      julia_mode_reg;
    logic [COUNT_W-1:0]        iter_limit_reg;
    logic [LIMIT_SQ_W-1:0]     escape_limit_sq_reg;

    // Sequencer and datapath registers.
    efp_state_t                state_reg, state_next;
    efp_in_t                   req_reg, req_next;
    logic signed [VAL_W-1:0]   zr_reg, zr_next;
    logic signed [VAL_W-1:0]   zi_reg, zi_next;
    logic signed [VAL_W-1:0]   cr_reg, cr_next;
    logic signed [VAL_W-1:0]   ci_reg, ci_next;
    logic signed [PROD_W-1:0]  rr_reg, rr_next;
    logic signed [PROD_W-1:0]  ii_reg, ii_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    efp_out_t                  result_reg, result_next;
    logic                      done_reg, done_next;

    // Shared units.
    logic signed [VAL_W-1:0]   mul_a;
    logic signed [VAL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  prod_fl;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_Q_W-1:0]        div_q;
    logic [DIVIDEND_W-1:0]     div_dividend;

    // Combinational arithmetic around the multiplier.
    logic signed [SUM_W-1:0]   re_pt_sum;
    logic signed [SUM_W-1:0]   im_pt_sum;
    logic signed [VAL_W-1:0]   re_pt;
    logic signed [VAL_W-1:0]   im_pt;
    logic signed [SUM_W-1:0]   nr_sum;
    logic signed [SUM_W-1:0]   ni_sum;
    logic [MOD_W-1:0]          mod_sum;
    logic                      escaped;
    logic                      last_iter;
    logic [COLOUR_W-1:0]       ramp_red;
    logic [COLOUR_W-1:0]       ramp_green;
    logic [COLOUR_W-1:0]       ramp_blue;

    efp_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    efp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (iter_limit_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg       <= -32'sd33554432;
            origin_im_reg       <= -32'sd33554432;
            pixel_step_reg      <= 31'd65536;
            julia_re_reg        <= '0;
            julia_im_reg        <= '0;
            julia_mode_reg      <= 1'b0;
            iter_limit_reg      <= 16'd256;
            escape_limit_sq_reg <= 31'd67108864;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ORIGIN_RE:  origin_re_reg       <= wr_data;
                CFG_ORIGIN_IM:  origin_im_reg       <= wr_data;
                CFG_PIXEL_STEP: pixel_step_reg      <= wr_data[STEP_W-1:0];
                CFG_JULIA_RE:   julia_re_reg        <= wr_data;
                CFG_JULIA_IM:   julia_im_reg        <= wr_data;
                CFG_JULIA_MODE: julia_mode_reg      <= wr_data[0];
                CFG_ITER_LIMIT: iter_limit_reg      <= wr_data[COUNT_W-1:0];
                CFG_ESC_LIMIT:  escape_limit_sq_reg <= wr_data[LIMIT_SQ_W-1:0];
                default:        ;
            endcase
        end
    end

    // Products are floored to the fixed-point grid by an arithmetic shift.
    assign prod_fl = mul_p >>> FRAC_BITS;

    // Point mapping: corner plus the exact index-times-step product.
    assign re_pt_sum = SUM_W'(origin_re_reg) + SUM_W'(mul_p);
    assign im_pt_sum = SUM_W'(origin_im_reg) + SUM_W'(mul_p);
    assign re_pt     = sat32(re_pt_sum);
    assign im_pt     = sat32(im_pt_sum);

    // New z from the three floored products of the current z.
    assign nr_sum = SUM_W'(rr_reg) - SUM_W'(ii_reg) + SUM_W'(cr_reg);
    assign ni_sum = (SUM_W'(prod_fl) <<< 1) + SUM_W'(ci_reg);

    // Squared modulus of the new z; both squares are non-negative.
    assign mod_sum   = {1'b0, rr_reg} + {1'b0, prod_fl};
    assign escaped   = mod_sum > MOD_W'(escape_limit_sq_reg);
    assign last_iter = ({1'b0, count_reg} + 1'b1) == {1'b0, iter_limit_reg};

    // Ramp dividend count*510, formed as count*512 - count*2.
    assign div_dividend = (DIVIDEND_W'(count_reg) << DIV_Q_W) - (DIVIDEND_W'(count_reg) << 1);

    // Yellow-red-blue ramp from the quotient.
    always_comb
    begin
        if (div_q <= COLOUR_MAX)
        begin
            ramp_red   = COLOUR_MAX[COLOUR_W-1:0];
            ramp_green = COLOUR_W'(COLOUR_MAX - div_q);
            ramp_blue  = '0;
        end
        else
        begin
            ramp_red   = COLOUR_W'(COLOUR_SPAN - div_q);
            ramp_green = '0;
            ramp_blue  = COLOUR_W'(div_q - COLOUR_MAX);
        end
    end

    // Sequencer state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    // Next state, multiplier operands and register updates.
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        rr_next     = rr_reg;
        ii_next     = ii_reg;
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = pixel;
                    state_next = ST_PRE;
                end
            end

            // Column times step.
            ST_PRE:
            begin
                mul_a      = {{(VAL_W-COORD_W){1'b0}}, req_reg.pix_col};
                mul_b      = {1'b0, pixel_step_reg};
                state_next = ST_PIM;
            end

            // Real part of the point; row times step.
            ST_PIM:
            begin
                zr_next    = julia_mode_reg ? re_pt : '0;
                cr_next    = julia_mode_reg ? julia_re_reg : re_pt;
                mul_a      = {{(VAL_W-COORD_W){1'b0}}, req_reg.pix_row};
                mul_b      = {1'b0, pixel_step_reg};
                state_next = ST_ZRR;
            end

            // Imaginary part of the point; square of the initial real part.
            ST_ZRR:
            begin
                zi_next    = julia_mode_reg ? im_pt : '0;
                ci_next    = julia_mode_reg ? julia_im_reg : im_pt;
                count_next = '0;
                mul_a      = zr_reg;
                mul_b      = zr_reg;
                if (iter_limit_reg == '0)
                begin
                    result_next = '{req_reg.pix_col, req_reg.pix_row, 1'b0,
                                    iter_limit_reg, '0, '0, '0};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ZII;
                end
            end

            ST_ZII:
            begin
                rr_next    = prod_fl;
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                state_next = ST_RI;
            end

            ST_RI:
            begin
                ii_next    = prod_fl;
                mul_a      = zr_reg;
                mul_b      = zi_reg;
                state_next = ST_NEW;
            end

            // The cross product arrives; form the saturated new z.
            ST_NEW:
            begin
                zr_next    = sat32(nr_sum);
                zi_next    = sat32(ni_sum);
                state_next = ST_SQR;
            end

            // The squares of the new z also serve the next iteration.
            ST_SQR:
            begin
                mul_a      = zr_reg;
                mul_b      = zr_reg;
                state_next = ST_SQI;
            end

            ST_SQI:
            begin
                rr_next    = prod_fl;
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                state_next = ST_CMP;
            end

            // Escape test, then either finish or start the next cross product.
            ST_CMP:
            begin
                ii_next = prod_fl;
                if (escaped)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (last_iter)
                begin
                    result_next = '{req_reg.pix_col, req_reg.pix_row, 1'b0,
                                    iter_limit_reg, '0, '0, '0};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    mul_a      = zr_reg;
                    mul_b      = zi_reg;
                    state_next = ST_NEW;
                end
            end

            // Wait for the ramp index, then colour the pixel.
            ST_DIV:
            begin
                if (div_done)
                begin
                    result_next = '{req_reg.pix_col, req_reg.pix_row, 1'b1,
                                    count_reg, ramp_red, ramp_green, ramp_blue};
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- src/efp_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal port checker
// Watches the ports of the pixel unit and checks how requests, busy and
// results follow one another.
// ----------------------------------------------------------------------------
module efp_chk
    import efp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  done,
    input  efp_out_t              result
);

    // A taken request keeps the unit occupied in the next cycle.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but unit not busy");

    // The unit becomes free exactly when a result is presented.
    a_free_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("unit went idle without a result");

    // A result is only shown while no request is in progress.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Every result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Pixels that never escaped carry no colour.
    a_undrawn_black: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.draw |-> (result.red == '0) && (result.green == '0)
                                 && (result.blue == '0))
        else $error("undrawn pixel has a colour");

endmodule

bind escape_time_fractal_pixel_unit efp_chk u_efp_chk (.*);
